// File: design/mprs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mprs_pkg;

    localparam int NUM_MOTORS = 6;
    localparam int NUM_PARAMS = 45;
    localparam int MOT_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int DEPTH      = NUM_MOTORS * NUM_PARAMS;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam int ID_W     = 11;
    localparam int CMD_W    = 2;
    localparam int MSLOT_W  = 3;
    localparam int PSLOT_W  = 6;
    localparam int LEN_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int REQREG_W = 7;
    localparam int PROG_W   = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_BASE = 1'b1;

    localparam logic [ID_W-1:0]   COMMAND_BASE_RESET  = 11'd16;
    localparam logic [ID_W-1:0]   FEEDBACK_BASE_RESET = 11'd32;
    localparam logic [BYTE_W-1:0] REPLY_MARK          = 8'h33;
    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN       = 4'd8;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FRAME,
        KIND_POLL,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [MOT_W-1:0]    motor;
        logic                store_ok;
        logic [PSLOT_W-1:0]  slot;
        logic                slot_ok;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   value;
    } job_t;

    typedef struct packed {
        logic                frame_accepted;
        logic [MSLOT_W-1:0]  frame_motor;
        logic                value_stored;
        logic                request_valid;
        logic [ID_W-1:0]     request_device_id;
        logic [REQREG_W-1:0] request_register;
        logic [PROG_W-1:0]   sweep_progress;
        logic [WORD_W-1:0]   param_value;
    } result_t;

    // List position of a register number, or NUM_PARAMS when it is not listed.
    function automatic logic [PSLOT_W-1:0] slot_of(input logic [BYTE_W-1:0] reg_num);
        logic [PSLOT_W-1:0] slot;
        slot = PSLOT_W'(NUM_PARAMS);
        if (reg_num inside {[8'd0:8'd36]})
        begin
            slot = reg_num[PSLOT_W-1:0];
        end
        else if (reg_num inside {[8'd50:8'd55]})
        begin
            slot = PSLOT_W'(reg_num - 8'd13);
        end
        else if (reg_num == 8'd80)
        begin
            slot = 6'd43;
        end
        else if (reg_num == 8'd81)
        begin
            slot = 6'd44;
        end
        return slot;
    endfunction

    // Register number held at a list position.
    function automatic logic [REQREG_W-1:0] reg_of(input logic [PSLOT_W-1:0] slot);
        logic [REQREG_W-1:0] num;
        num = '0;
        if (slot inside {[6'd0:6'd36]})
        begin
            num = REQREG_W'(slot);
        end
        else if (slot inside {[6'd37:6'd42]})
        begin
            num = REQREG_W'(slot) + 7'd13;
        end
        else if (slot == 6'd43)
        begin
            num = 7'd80;
        end
        else if (slot == 6'd44)
        begin
            num = 7'd81;
        end
        return num;
    endfunction

endpackage

`default_nettype wire

// File: design/mprs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mprs_item_if import mprs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [MSLOT_W-1:0] motor_slot;
    logic [PSLOT_W-1:0] param_slot;
    logic [ID_W-1:0]    frame_id;
    logic               frame_is_standard;
    logic               frame_is_data;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  reply_marker;
    logic [BYTE_W-1:0]  reply_register;
    logic [WORD_W-1:0]  reply_value;

    modport source (
        output valid, command, motor_slot, param_slot, frame_id, frame_is_standard,
               frame_is_data, frame_length, reply_marker, reply_register, reply_value,
        input  ready
    );
    modport sink (
        input  valid, command, motor_slot, param_slot, frame_id, frame_is_standard,
               frame_is_data, frame_length, reply_marker, reply_register, reply_value,
        output ready
    );
endinterface

interface mprs_result_if import mprs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                frame_accepted;
    logic [MSLOT_W-1:0]  frame_motor;
    logic                value_stored;
    logic                request_valid;
    logic [ID_W-1:0]     request_device_id;
    logic [REQREG_W-1:0] request_register;
    logic [PROG_W-1:0]   sweep_progress;
    logic [WORD_W-1:0]   param_value;

    modport source (
        output valid, frame_accepted, frame_motor, value_stored, request_valid,
               request_device_id, request_register, sweep_progress, param_value,
        input  ready
    );
    modport sink (
        input  valid, frame_accepted, frame_motor, value_stored, request_valid,
               request_device_id, request_register, sweep_progress, param_value,
        output ready
    );
endinterface

`default_nettype wire

// File: design/mprs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mprs_front import mprs_pkg::*; (
    mprs_item_if.sink        item,
    input  wire [ID_W-1:0]   feedback_base,
    input  wire              clearing,
    input  wire              q_full,
    output logic             push,
    output job_t             job
);

    logic [ID_W:0]      fb_diff;
    logic               frame_ok;
    logic               motor_ok;
    logic [PSLOT_W-1:0] reply_slot;
    logic [MOT_W-1:0]   motor;
    logic [PSLOT_W-1:0] slot;

    assign item.ready = !q_full && !clearing;
    assign push       = item.valid && item.ready;

    assign fb_diff  = {1'b0, item.frame_id} - {1'b0, feedback_base};
    assign frame_ok = item.frame_is_standard && item.frame_is_data
                      && (item.frame_length >= MIN_FRAME_LEN)
                      && !fb_diff[ID_W]
                      && (32'(fb_diff[ID_W-1:0]) < 32'(NUM_MOTORS));
    assign motor_ok = 32'(item.motor_slot) < 32'(NUM_MOTORS);

    assign reply_slot = slot_of(item.reply_register);
    assign motor      = (item.command == CMD_FRAME) ? MOT_W'(fb_diff[ID_W-1:0])
                                                    : MOT_W'(item.motor_slot);
    assign slot       = (item.command == CMD_FRAME) ? reply_slot : item.param_slot;

    always_comb
    begin
        job.motor    = motor;
        job.slot     = slot;
        job.store_ok = (item.reply_marker == REPLY_MARK)
                       && (reply_slot < PSLOT_W'(NUM_PARAMS));
        job.slot_ok  = item.param_slot < PSLOT_W'(NUM_PARAMS);
        job.addr     = ADDR_W'(motor) * ADDR_W'(NUM_PARAMS) + ADDR_W'(slot);
        job.value    = item.reply_value;
        case (item.command)
            CMD_FRAME: job.kind = frame_ok ? KIND_FRAME : KIND_NONE;
            CMD_POLL:  job.kind = motor_ok ? KIND_POLL : KIND_NONE;
            CMD_READ:  job.kind = motor_ok ? KIND_READ : KIND_NONE;
            default:   job.kind = KIND_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: design/mprs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mprs_queue import mprs_pkg::*; (
    input  wire   clk,
    input  wire   rst_n,
    input  wire   push,
    input  job_t  job_in,
    input  wire   pop,
    output job_t  job_out,
    output logic  empty,
    output logic  full
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign job_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("Queue read while empty.");

endmodule

`default_nettype wire

// File: design/mprs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mprs_back import mprs_pkg::*; (
    input  wire              clk,
    input  wire              rst_n,
    input  job_t             job,
    input  wire              q_empty,
    input  wire [ID_W-1:0]   command_base,
    output logic             pop,
    output logic             clearing,
    mprs_result_if.source    result
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;
    logic [PROG_W-1:0] progress_reg [NUM_MOTORS];
    logic [PROG_W-1:0] progress_next [NUM_MOTORS];
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           out_next;
    logic [PROG_W-1:0] pend_prog_reg;
    logic [PROG_W-1:0] pend_prog_next;
    logic              pend_slot_ok_reg;
    logic              pend_slot_ok_next;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;

    logic              slot_free;
    logic [PROG_W-1:0] cur_prog;
    logic              store;
    logic [PROG_W-1:0] new_prog;
    result_t           res;

    assign clearing  = (state_reg == ST_CLEAR);
    assign slot_free = !out_valid_reg || result.ready;
    assign pop       = (state_reg == ST_RUN) && !q_empty && slot_free;
    assign cur_prog  = progress_reg[job.motor];
    assign store     = (job.kind == KIND_FRAME) && job.store_ok && (cur_prog != '0);
    assign new_prog  = (job.slot < PSLOT_W'(NUM_PARAMS - 1))
                       ? PROG_W'(job.slot) + PROG_W'(2) : '0;

    assign mem_we    = clearing || (pop && store);
    assign mem_waddr = clearing ? clear_addr_reg : job.addr;
    assign mem_wdata = clearing ? '0 : job.value;
    assign mem_re    = pop && (job.kind == KIND_READ);

    always_comb
    begin
        res = '0;
        case (job.kind)
            KIND_FRAME:
            begin
                res.frame_accepted = 1'b1;
                res.frame_motor    = MSLOT_W'(job.motor);
                res.value_stored   = store;
                res.sweep_progress = store ? new_prog : cur_prog;
            end
            KIND_POLL:
            begin
                if ((cur_prog != '0) && (cur_prog <= PROG_W'(NUM_PARAMS)))
                begin
                    res.request_valid     = 1'b1;
                    res.request_device_id = command_base + ID_W'(job.motor);
                    res.request_register  = reg_of(PSLOT_W'(cur_prog - PROG_W'(1)));
                    res.sweep_progress    = cur_prog;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        clear_addr_next   = clear_addr_reg;
        progress_next     = progress_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_next          = out_reg;
        pend_prog_next    = pend_prog_reg;
        pend_slot_ok_next = pend_slot_ok_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pop)
                begin
                    if (job.kind == KIND_READ)
                    begin
                        pend_prog_next    = cur_prog;
                        pend_slot_ok_next = job.slot_ok;
                        state_next        = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next       = res;
                        if (store)
                        begin
                            progress_next[job.motor] = new_prog;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next                = '0;
                    out_next.sweep_progress = pend_prog_reg;
                    out_next.param_value    = pend_slot_ok_reg ? rd_data_reg : '0;
                    state_next              = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                progress_reg[i] <= PROG_W'(1);
            end
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
            progress_reg   <= progress_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg          <= out_next;
        pend_prog_reg    <= pend_prog_next;
        pend_slot_ok_reg <= pend_slot_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[job.addr];
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.frame_accepted    = out_reg.frame_accepted;
    assign result.frame_motor       = out_reg.frame_motor;
    assign result.value_stored      = out_reg.value_stored;
    assign result.request_valid     = out_reg.request_valid;
    assign result.request_device_id = out_reg.request_device_id;
    assign result.request_register  = out_reg.request_register;
    assign result.sweep_progress    = out_reg.sweep_progress;
    assign result.param_value       = out_reg.param_value;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop)
        else $error("Job taken during the store clearing pass.");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (job.kind != KIND_READ) |=> out_valid_reg)
        else $error("Frame or poll job produced no result beat.");

    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (job.kind == KIND_READ) |=> (state_reg == ST_READ) && !pop)
        else $error("Read job did not wait for the store data.");

    a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.request_valid |-> out_reg.sweep_progress != '0)
        else $error("Read request issued for a finished sweep.");

endmodule

`default_nettype wire

// File: design/motor_parameter_readback_sweep_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role   Beat contents
// item      sink   command, motor and list slot, CAN frame header and data bytes
// result    source frame, request and readback fields, one beat per item
// wr_*      write  command_id_base (index 0), feedback_id_base (index 1)
//
// After reset the block zeroes all DEPTH (270) words of the parameter store;
// item.ready stays low during that pass.
// A frame or poll beat is registered into a free result slot as its job leaves
// the queue; a read waits in ST_READ, holding the queue, for the registered read.
// Frames and polls retire one per cycle while the result slot is free.
// A two-entry queue lets items be accepted while a result beat is stalled.

module motor_parameter_readback_sweep_top import mprs_pkg::*; (
    input  wire                   clk,
    input  wire                   rst_n,
    mprs_item_if.sink             item,
    mprs_result_if.source         result,
    input  wire                   wr_en,
    input  wire [CFG_IDX_W-1:0]   wr_index,
    input  wire [ID_W-1:0]        wr_data
);

    logic [ID_W-1:0] command_base_reg;
    logic [ID_W-1:0] feedback_base_reg;

    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;
    logic            clearing;
    job_t            job_in;
    job_t            job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_base_reg  <= COMMAND_BASE_RESET;
            feedback_base_reg <= FEEDBACK_BASE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_COMMAND_BASE:  command_base_reg  <= wr_data;
                CFG_FEEDBACK_BASE: feedback_base_reg <= wr_data;
                default:           command_base_reg  <= command_base_reg;
            endcase
        end
    end

    mprs_front u_front (
        .item          (item),
        .feedback_base (feedback_base_reg),
        .clearing      (clearing),
        .q_full        (q_full),
        .push          (push),
        .job           (job_in)
    );

    mprs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_out),
        .empty   (q_empty),
        .full    (q_full)
    );

    mprs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job_out),
        .q_empty      (q_empty),
        .command_base (command_base_reg),
        .pop          (pop),
        .clearing     (clearing),
        .result       (result)
    );

endmodule

`default_nettype wire
